// ===== rtl/core/tiex_pkg.sv =====
// Shared types, operation codes and helper functions of the tiny execute unit.
`timescale 1ns / 1ps

package tiex_pkg;

	// Operation codes carried in the action field
	localparam logic [2:0] OP_MOV = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_CMP = 3'd2;
	localparam logic [2:0] OP_JE  = 3'd3;
	localparam logic [2:0] OP_JMP = 3'd4;
	localparam logic [2:0] OP_LD  = 3'd5;
	localparam logic [2:0] OP_ST  = 3'd6;
	localparam logic [2:0] OP_END = 3'd7;

	// Stream widths
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 144;

	// Configuration and counter constants
	localparam logic [7:0] MISS_PENALTY_RESET = 8'd48;
	localparam int         CNT_W              = 32;
	localparam int         AMT_W              = 10;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// One classified instruction as held in the queue
	typedef struct packed {
		logic [2:0] op;
		logic       fault;
		logic [7:0] opa;
		logic [7:0] opb;
		logic       opb_reg;
		logic [7:0] seq_addr;
	} instr_t;

	// Statistics counters, executed count in the lowest bits
	typedef struct packed {
		logic [CNT_W-1:0] mem_acc;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] cycles;
		logic [CNT_W-1:0] executed;
	} counters_t;

	// One result item as it leaves on the master side
	typedef struct packed {
		logic [5:0] pad;
		counters_t  cnt;
		logic       fault;
		logic       halted;
		logic [7:0] next_address;
	} result_t;

	// Run status reported by the back end
	typedef struct packed {
		logic halted;
		logic fault;
	} status_t;

	// Saturating add of a small amount to a counter
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [AMT_W-1:0] amt);
		logic [CNT_W:0] s;
		s = {1'b0, v} + (CNT_W+1)'(amt);
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/tiex_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module tiex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and registered read of both ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/core/tiex_front.sv =====
// Front end: accepts instruction transfers and classifies them for the back end.
`timescale 1ns / 1ps

module tiex_front #(
	parameter int REG_COUNT = 6
) (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tiex_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           q_full,
	output logic                           q_push,
	output tiex_pkg::instr_t               q_entry
);

	localparam logic [7:0] REG_MAX = 8'(REG_COUNT);

	logic [2:0] op;
	logic [7:0] opa;
	logic [7:0] opb;
	logic [7:0] pc;
	logic       need_a;
	logic       need_b;
	logic       ok_a;
	logic       ok_b;

	// Field unpacking
	assign op  = s_axis_tdata[2:0];
	assign opa = s_axis_tdata[10:3];
	assign opb = s_axis_tdata[18:11];
	assign pc  = s_axis_tdata[26:19];

	// Which operand positions name a register
	always_comb begin
		need_a = 1'b1;
		need_b = 1'b0;
		unique case (op) inside
			tiex_pkg::OP_JE, tiex_pkg::OP_JMP, tiex_pkg::OP_END: begin
				need_a = 1'b0;
			end
			tiex_pkg::OP_CMP, tiex_pkg::OP_LD, tiex_pkg::OP_ST: begin
				need_b = 1'b1;
			end
			tiex_pkg::OP_ADD: begin
				need_b = s_axis_tuser;
			end
			default: begin
				need_b = 1'b0;
			end
		endcase
	end

	// Register numbers are valid from one up to the register count.
	assign ok_a = (opa != 8'd0) && (opa <= REG_MAX);
	assign ok_b = (opb != 8'd0) && (opb <= REG_MAX);

	// Queue entry and handshake
	assign s_axis_tready    = !q_full;
	assign q_push           = s_axis_tvalid && !q_full;
	assign q_entry.op       = op;
	assign q_entry.fault    = (need_a && !ok_a) || (need_b && !ok_b);
	assign q_entry.opa      = opa;
	assign q_entry.opb      = opb;
	assign q_entry.opb_reg  = s_axis_tuser;
	assign q_entry.seq_addr = pc + 8'd1;

endmodule

// ===== rtl/core/tiex_queue.sv =====
// Short queue of classified instructions between the front and back ends.
`timescale 1ns / 1ps

module tiex_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tiex_pkg::instr_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output tiex_pkg::instr_t head
);

	tiex_pkg::instr_t               entry_q [tiex_pkg::Q_DEPTH];
	logic [tiex_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [tiex_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [tiex_pkg::Q_PTR_W:0]     count_q;

	localparam logic [tiex_pkg::Q_PTR_W-1:0] PTR_LAST = tiex_pkg::Q_PTR_W'(tiex_pkg::Q_DEPTH - 1);
	localparam logic [tiex_pkg::Q_PTR_W:0]   CNT_FULL = (tiex_pkg::Q_PTR_W+1)'(tiex_pkg::Q_DEPTH);

	assign full  = (count_q == CNT_FULL);
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/tiex_back.sv =====
// Back end: executes queued instructions against the register file and data store.
`timescale 1ns / 1ps

module tiex_back #(
	parameter int MEM_DEPTH = 256,
	parameter int REG_COUNT = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      miss_penalty,
	input  logic                            q_valid,
	input  tiex_pkg::instr_t                q_head,
	output logic                            q_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tiex_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output tiex_pkg::status_t               status
);

	localparam int RIW = $clog2(REG_COUNT);
	localparam int AW  = $clog2(MEM_DEPTH);

	// Sequencer codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_EXEC = 2'd1;
	localparam logic [1:0] PH_WB   = 2'd2;

	// Reduces a byte modulo the data store depth by binary long division.
	function automatic logic [AW-1:0] addr_of(input logic [7:0] v);
		logic [11:0] r;
		r = {4'b0, v};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (12'(MEM_DEPTH) << k)) begin
				r = r - (12'(MEM_DEPTH) << k);
			end
		end
		return AW'(r);
	endfunction

	logic [1:0]          phase_q;
	tiex_pkg::instr_t    cur_q;
	logic                eq_q;
	logic                halted_q;
	logic                fault_q;
	tiex_pkg::counters_t cnt_q;
	tiex_pkg::counters_t cnt_nxt;
	logic [REG_COUNT-1:0] rf_vld_q;
	logic [MEM_DEPTH-1:0] touched_q;
	logic                vld_a_q;
	logic                vld_b_q;
	logic                ld_hit_q;
	logic                out_valid_q;
	tiex_pkg::result_t   out_data_q;
	tiex_pkg::result_t   res;

	logic [RIW-1:0] rd_idx_a;
	logic [RIW-1:0] rd_idx_b;
	logic           vld_a;
	logic           vld_b;
	logic [7:0]     rf_rdata_a;
	logic [7:0]     rf_rdata_b;
	logic           rf_we;
	logic [RIW-1:0] rf_waddr;
	logic [7:0]     rf_wdata;
	logic [7:0]     ra;
	logic [7:0]     rb;

	logic           ex;
	logic           wb;
	logic           out_free;
	logic           live;
	logic           do_end;
	logic           do_fault;
	logic           do_run;
	logic           ld_run;
	logic           mem_op;
	logic           ex_go;
	logic           out_load;
	logic [AW-1:0]  mem_addr;
	logic           was_touched;
	logic           ds_we;
	logic           ds_re;
	logic [7:0]     ds_wdata;
	logic [7:0]     ds_rdata;
	logic           exec_inc;
	logic [tiex_pkg::AMT_W-1:0] cyc_amt;
	logic           halted_nxt;
	logic           fault_nxt;
	logic           jump_taken;

	// Phase decode and output slot
	assign ex       = (phase_q == PH_EXEC);
	assign wb       = (phase_q == PH_WB);
	assign out_free = !out_valid_q || m_axis_tready;
	assign q_pop    = (phase_q == PH_IDLE) && q_valid;

	// Register file read addresses come straight from the queue head.
	assign rd_idx_a = RIW'(q_head.opa - 8'd1);
	assign rd_idx_b = RIW'(q_head.opb - 8'd1);
	assign vld_a    = (int'(rd_idx_a) < REG_COUNT) ? rf_vld_q[rd_idx_a] : 1'b0;
	assign vld_b    = (int'(rd_idx_b) < REG_COUNT) ? rf_vld_q[rd_idx_b] : 1'b0;

	tiex_ram #(
		.WIDTH (8),
		.DEPTH (REG_COUNT)
	) u_regs (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.re      (q_pop),
		.raddr_a (rd_idx_a),
		.rdata_a (rf_rdata_a),
		.raddr_b (rd_idx_b),
		.rdata_b (rf_rdata_b)
	);

	// A register never written since reset reads as zero.
	assign ra = vld_a_q ? rf_rdata_a : 8'd0;
	assign rb = vld_b_q ? rf_rdata_b : 8'd0;

	// Classification of the instruction in execution
	assign live     = !halted_q;
	assign do_end   = live && (cur_q.op == tiex_pkg::OP_END);
	assign do_fault = live && !do_end && cur_q.fault;
	assign do_run   = live && !do_end && !cur_q.fault;
	assign mem_op   = do_run && ((cur_q.op == tiex_pkg::OP_LD) || (cur_q.op == tiex_pkg::OP_ST));
	assign ld_run   = do_run && (cur_q.op == tiex_pkg::OP_LD);
	assign ex_go    = ex && (ld_run || out_free);
	assign out_load = (ex && !ld_run && out_free) || (wb && out_free);

	// Data address and first-touch lookup
	assign mem_addr    = addr_of(ld_run ? rb : ra);
	assign was_touched = touched_q[mem_addr];

	// Data store access: a load of an untouched byte writes zero instead of reading.
	always_comb begin
		ds_we    = 1'b0;
		ds_re    = 1'b0;
		ds_wdata = rb;
		if (ex_go && mem_op) begin
			if (ld_run) begin
				ds_re    = was_touched;
				ds_we    = !was_touched;
				ds_wdata = 8'd0;
			end else begin
				ds_we = 1'b1;
			end
		end
	end

	tiex_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_data (
		.clk     (clk),
		.we      (ds_we),
		.waddr   (mem_addr),
		.wdata   (ds_wdata),
		.re      (ds_re),
		.raddr_a (mem_addr),
		.rdata_a (ds_rdata),
		.raddr_b (mem_addr),
		.rdata_b ()
	);

	// Register file write: ALU results in execute, load data in write-back.
	assign rf_waddr = RIW'(cur_q.opa - 8'd1);
	always_comb begin
		rf_we    = 1'b0;
		rf_wdata = ld_hit_q ? ds_rdata : 8'd0;
		if (wb) begin
			rf_we = out_free;
		end else if (ex_go && do_run) begin
			unique case (cur_q.op)
				tiex_pkg::OP_MOV: begin
					rf_we    = 1'b1;
					rf_wdata = cur_q.opb;
				end
				tiex_pkg::OP_ADD: begin
					rf_we    = 1'b1;
					rf_wdata = ra + (cur_q.opb_reg ? rb : cur_q.opb);
				end
				default: begin
					rf_we = 1'b0;
				end
			endcase
		end
	end

	// Counter increments of the instruction in execute
	assign exec_inc = ex && (do_run || do_fault);
	assign cyc_amt  = tiex_pkg::AMT_W'(exec_inc) + tiex_pkg::AMT_W'(ex && mem_op)
		+ ((ex && mem_op && !was_touched) ? tiex_pkg::AMT_W'(miss_penalty)
		: tiex_pkg::AMT_W'(0));

	assign cnt_nxt.executed = tiex_pkg::sat_add(cnt_q.executed, tiex_pkg::AMT_W'(exec_inc));
	assign cnt_nxt.cycles   = tiex_pkg::sat_add(cnt_q.cycles, cyc_amt);
	assign cnt_nxt.hits     = tiex_pkg::sat_add(cnt_q.hits,
		tiex_pkg::AMT_W'(ex && mem_op && was_touched));
	assign cnt_nxt.mem_acc  = tiex_pkg::sat_add(cnt_q.mem_acc, tiex_pkg::AMT_W'(ex && mem_op));

	// Stop status and next fetch address
	assign halted_nxt = halted_q || (ex && (do_end || do_fault));
	assign fault_nxt  = fault_q || (ex && do_fault);
	assign jump_taken = ex && do_run
		&& ((cur_q.op == tiex_pkg::OP_JMP) || ((cur_q.op == tiex_pkg::OP_JE) && eq_q));

	assign res.pad          = '0;
	assign res.cnt          = cnt_nxt;
	assign res.fault        = fault_nxt;
	assign res.halted       = halted_nxt;
	assign res.next_address = halted_nxt ? 8'd0 : (jump_taken ? cur_q.opa : cur_q.seq_addr);

	// Sequencer: issue, execute, and write-back for loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (q_valid) begin
						phase_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					if (ld_run) begin
						phase_q <= PH_WB;
					end else if (out_free) begin
						phase_q <= PH_IDLE;
					end
				end
				PH_WB: begin
					if (out_free) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Current instruction and read-side state
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q   <= q_head;
			vld_a_q <= vld_a;
			vld_b_q <= vld_b;
		end
		if (ex_go) begin
			ld_hit_q <= was_touched;
		end
		if (out_load) begin
			out_data_q <= res;
		end
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_q      <= 1'b0;
			halted_q  <= 1'b0;
			fault_q   <= 1'b0;
			cnt_q     <= '0;
			rf_vld_q  <= '0;
			touched_q <= '0;
		end else begin
			if (ex_go) begin
				cnt_q    <= cnt_nxt;
				halted_q <= halted_nxt;
				fault_q  <= fault_nxt;
				if (do_run && (cur_q.op == tiex_pkg::OP_CMP)) begin
					eq_q <= (ra == rb);
				end else if (jump_taken && (cur_q.op == tiex_pkg::OP_JE)) begin
					eq_q <= 1'b0;
				end
				if (mem_op) begin
					touched_q[mem_addr] <= 1'b1;
				end
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign status.halted = halted_q;
	assign status.fault  = fault_q;

endmodule

// ===== rtl/core/tiny_isa_execute_unit.sv =====
// Top level of the tiny execute unit: configuration register, front, queue and back.
`timescale 1ns / 1ps

// Executes one decoded instruction per transfer on the slave stream and returns
// one result transfer per instruction on the master stream, in order.
// The slave side carries the instruction; tuser flags a register addend for ADD.
// The master side carries the next fetch address, halt and fault flags and four
// saturating statistics counters.
// cfg_we with cfg_wdata sets the miss penalty; write it only while the unit is idle.
// An accepted transfer waits in the queue, is issued with a register file read and
// executed, and its result is registered at the output; a load adds a write-back.
// The back end takes one instruction at a time: it issues a register file read,
// executes, and for a load adds a data store read, before it issues the next one.
// A two-entry queue keeps accepting transfers while the back end works or waits.
// Reset clears the registers, the equal flag, the first-touch marks, the halt
// state and the counters, and sets the miss penalty to 48; no clearing pass runs.
// When the receiver stalls, the finished result is held and the back end waits;
// the input side stops only once the queue is full.
module tiny_isa_execute_unit #(
	parameter int MEM_DEPTH = 256,
	parameter int REG_COUNT = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [7:0]                      cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: action[2:0], first_operand[10:3], second_operand[18:11],
	// instr_address[26:19], zero fill [31:27]
	input  logic [tiex_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: second_is_register
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: next_address[7:0], halted[8], fault[9], executed_count[41:10],
	// cycle_total[73:42], local_hits[105:74], memory_accesses[137:106], zero fill
	output logic [tiex_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic              [7:0] miss_penalty_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	tiex_pkg::instr_t  q_entry;
	tiex_pkg::instr_t  q_head;
	tiex_pkg::status_t status;

	// Miss penalty register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_penalty_q <= tiex_pkg::MISS_PENALTY_RESET;
		end else if (cfg_we) begin
			miss_penalty_q <= cfg_wdata;
		end
	end

	tiex_front #(
		.REG_COUNT (REG_COUNT)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_entry)
	);

	tiex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	tiex_back #(
		.MEM_DEPTH (MEM_DEPTH),
		.REG_COUNT (REG_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.miss_penalty  (miss_penalty_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.status        (status)
	);

`ifndef SYNTHESIS
	// Once stopped, the unit stays stopped until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |=> status.halted)
		else $error("halt state was left without reset");

	// A fault always comes with a halt.
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		status.fault |-> status.halted)
		else $error("fault set while running");

	// Hits never exceed accesses, accesses never exceed executed, nor executed cycles.
	a_counter_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[105:74] <= m_axis_tdata[137:106])
			&& (m_axis_tdata[137:106] <= m_axis_tdata[41:10])
			&& (m_axis_tdata[41:10] <= m_axis_tdata[73:42]))
		else $error("statistics counters out of order");
`endif

endmodule
